// ----- src/erlang_b_channel_dimensioner_defines.svh -----
`ifndef ERLANG_B_CHANNEL_DIMENSIONER_DEFINES_SVH
`define ERLANG_B_CHANNEL_DIMENSIONER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define EBCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define EBCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ebcd_pkg.sv -----
`timescale 1ns / 1ps

package ebcd_pkg;

  // Field widths
  localparam int TrafficW        = 20;
  localparam int CountW          = 10;
  localparam int ProbW           = 25;

  // Fixed-point formats
  localparam int TrafficFracBits = 10;
  localparam int ProbFracBits    = 24;

  // Largest channel count; equals the full range of a count field
  localparam int MaxChannels     = 1023;

  // Datapath widths: A*B product, A*B truncated to Q.24, divisor
  localparam int ProdW           = TrafficW + ProbW;
  localparam int AbW             = ProdW - TrafficFracBits - 1;
  localparam int DenW            = AbW + 1;

  // Step counters of the serial units
  localparam int MulCntW         = $clog2(TrafficW);
  localparam int DivCntW         = $clog2(ProbFracBits);

  localparam logic [CountW-1:0] SearchLimitReset = CountW'(1000);
  localparam logic [ProbW-1:0]  ProbOne          = ProbW'(1) << ProbFracBits;

endpackage

// ----- src/ebcd_mul.sv -----
`timescale 1ns / 1ps

// Bit-serial A*B: one traffic bit per cycle, LSB first, shift-right accumulator.
module ebcd_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ebcd_pkg::TrafficW-1:0] traffic_i,
  input  logic [ebcd_pkg::ProbW-1:0]  prob_i,
  output logic                        done_o,
  output logic [ebcd_pkg::AbW-1:0]    ab_o
);
  import ebcd_pkg::*;

  logic               run_q, run_d;
  logic               done_q, done_d;
  logic [MulCntW-1:0] cnt_q, cnt_d;
  logic [TrafficW-1:0] mplr_q, mplr_d;
  logic [ProbW-1:0]   mcand_q, mcand_d;
  logic [ProdW-1:0]   prod_q, prod_d;
  logic [ProbW:0]     hi;

  // Add the multiplicand into the upper half when the current bit is set
  always_comb begin
    hi = {1'b0, prod_q[ProdW-1:TrafficW]} + (mplr_q[0] ? {1'b0, mcand_q} : '0);
  end

  always_comb begin
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    mplr_d  = mplr_q;
    mcand_d = mcand_q;
    prod_d  = prod_q;
    if (start_i) begin
      run_d   = 1'b1;
      cnt_d   = '0;
      mplr_d  = traffic_i;
      mcand_d = prob_i;
      prod_d  = '0;
    end else if (run_q) begin
      prod_d = {hi, prod_q[TrafficW-1:1]};
      mplr_d = mplr_q >> 1;
      cnt_d  = cnt_q + MulCntW'(1);
      if (cnt_q == MulCntW'(TrafficW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mplr_q  <= mplr_d;
    mcand_q <= mcand_d;
    prod_q  <= prod_d;
  end

  // Drop the traffic fraction bits; the product is known to fit in AbW bits
  assign done_o = done_q;
  assign ab_o   = prod_q[TrafficFracBits+AbW-1:TrafficFracBits];

endmodule

// ----- src/ebcd_div.sv -----
`timescale 1ns / 1ps

// Restoring divider: floor(ab * 2^24 / (i * 2^24 + ab)), one quotient bit per cycle.
module ebcd_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ebcd_pkg::AbW-1:0]        ab_i,
  input  logic [ebcd_pkg::CountW-1:0]     idx_i,
  output logic                            done_o,
  output logic [ebcd_pkg::ProbFracBits-1:0] quo_o
);
  import ebcd_pkg::*;

  logic                    run_q, run_d;
  logic                    done_q, done_d;
  logic [DivCntW-1:0]      cnt_q, cnt_d;
  logic [DenW-1:0]         rem_q, rem_d;
  logic [DenW-1:0]         den_q, den_d;
  logic [ProbFracBits-1:0] quo_q, quo_d;
  logic [DenW:0]           trial;
  logic                    fits;

  // Shift the partial remainder and test it against the divisor
  always_comb begin
    trial = {rem_q, 1'b0};
    fits  = trial >= {1'b0, den_q};
  end

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      // ab is below the divisor, so it is the first partial remainder
      rem_d = DenW'(ab_i);
      den_d = {1'b0, idx_i, {ProbFracBits{1'b0}}} + DenW'(ab_i);
      quo_d = '0;
    end else if (run_q) begin
      rem_d = fits ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      quo_d = {quo_q[ProbFracBits-2:0], fits};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(ProbFracBits - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- src/erlang_b_channel_dimensioner.sv -----
`timescale 1ns / 1ps
`include "erlang_b_channel_dimensioner_defines.svh"

// Channel  | Ports                                                  | Handshake
// ---------+--------------------------------------------------------+--------------------------
// request  | offered_traffic_i, channel_count_i, target_blocking_i  | start high, busy low
// result   | blocking_prob_o, required_channels_o,                  | done_o strobe, one cycle
//          | search_exhausted_o                                     |
// config   | cfg_wdata_i (search_limit)                             | cfg_we_i, write at edge
//
// One word runs L recursion steps, L = max(channel_count, search_limit) when a
// search is made, else channel_count. Each step is a bit-serial multiply followed
// by a restoring divide, so busy stays high from the accepting edge until the last
// step has ended, and done_o is high in the first cycle with busy low (L = 0: the
// cycle right after the accepting edge). Reset clears the sequencer and loads a
// search limit of 1000. The result strobe cannot be held off by the receiver.
module erlang_b_channel_dimensioner (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [ebcd_pkg::TrafficW-1:0]   offered_traffic_i,
  input  logic [ebcd_pkg::CountW-1:0]     channel_count_i,
  input  logic [ebcd_pkg::ProbW-1:0]      target_blocking_i,
  input  logic                            cfg_we_i,
  input  logic [ebcd_pkg::CountW-1:0]     cfg_wdata_i,
  output logic                            done_o,
  output logic [ebcd_pkg::ProbW-1:0]      blocking_prob_o,
  output logic [ebcd_pkg::CountW-1:0]     required_channels_o,
  output logic                            search_exhausted_o
);
  import ebcd_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StMul  = 2'd1;
  localparam logic [1:0] StDiv  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic                done_q, done_d;
  logic [CountW-1:0]   limit_cfg_q;

  logic [TrafficW-1:0] traffic_q, traffic_d;
  logic [ProbW-1:0]    prob_q, prob_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [ProbW-1:0]    target_q, target_d;
  logic [CountW-1:0]   limit_q, limit_d;
  logic [CountW-1:0]   last_q, last_d;
  logic [CountW-1:0]   i_q, i_d;
  logic                searching_q, searching_d;
  logic                found_q, found_d;
  logic [ProbW-1:0]    blocking_q, blocking_d;
  logic [CountW-1:0]   required_q, required_d;
  logic                exhausted_q, exhausted_d;

  logic                searching_in;
  logic [CountW-1:0]   last_in;
  logic                mul_start, mul_done, div_done;
  logic [AbW-1:0]      ab;
  logic [ProbFracBits-1:0] quo;
  logic [ProbW-1:0]    prob_new;
  logic                meets;

  // Load the multiplier with the operands of the step that starts now
  ebcd_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .traffic_i (traffic_d),
    .prob_i    (prob_d),
    .done_o    (mul_done),
    .ab_o      (ab)
  );

  ebcd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_done),
    .ab_i    (ab),
    .idx_i   (i_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // Counts are 10 bits wide, so they never exceed MaxChannels and need no clamp
  always_comb begin
    searching_in = (|offered_traffic_i) && (|target_blocking_i);
    last_in      = (searching_in && (limit_cfg_q > channel_count_i)) ? limit_cfg_q
                                                                    : channel_count_i;
    prob_new     = ProbW'(quo);
    meets        = searching_q && !found_q && (i_q <= limit_q) && (prob_new <= target_q);
  end

  // Sequence the recursion: multiply, divide, fold the new blocking value in
  always_comb begin
    state_d     = state_q;
    done_d      = 1'b0;
    mul_start   = 1'b0;
    traffic_d   = traffic_q;
    prob_d      = prob_q;
    count_d     = count_q;
    target_d    = target_q;
    limit_d     = limit_q;
    last_d      = last_q;
    i_d         = i_q;
    searching_d = searching_q;
    found_d     = found_q;
    blocking_d  = blocking_q;
    required_d  = required_q;
    exhausted_d = exhausted_q;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          traffic_d   = offered_traffic_i;
          prob_d      = ProbOne;
          count_d     = channel_count_i;
          target_d    = target_blocking_i;
          limit_d     = limit_cfg_q;
          last_d      = last_in;
          i_d         = CountW'(1);
          searching_d = searching_in;
          found_d     = 1'b0;
          blocking_d  = '0;
          required_d  = '0;
          exhausted_d = 1'b0;
          if (last_in == '0) begin
            // Nothing to iterate: an empty search limit leaves the search unmet
            exhausted_d = searching_in;
            done_d      = 1'b1;
          end else begin
            mul_start = 1'b1;
            state_d   = StMul;
          end
        end
      end
      StMul: begin
        if (mul_done) begin
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          prob_d = prob_new;
          if (i_q == count_q) begin
            blocking_d = prob_new;
          end
          if (meets) begin
            found_d    = 1'b1;
            required_d = i_q;
          end
          if (i_q == last_q) begin
            exhausted_d = searching_q && !(found_q || meets);
            done_d      = 1'b1;
            state_d     = StIdle;
          end else begin
            i_d       = i_q + CountW'(1);
            mul_start = 1'b1;
            state_d   = StMul;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      done_q      <= 1'b0;
      limit_cfg_q <= SearchLimitReset;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        limit_cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    traffic_q   <= traffic_d;
    prob_q      <= prob_d;
    count_q     <= count_d;
    target_q    <= target_d;
    limit_q     <= limit_d;
    last_q      <= last_d;
    i_q         <= i_d;
    searching_q <= searching_d;
    found_q     <= found_d;
    blocking_q  <= blocking_d;
    required_q  <= required_d;
    exhausted_q <= exhausted_d;
  end

  assign busy                = (state_q != StIdle);
  assign done_o              = done_q;
  assign blocking_prob_o     = blocking_q;
  assign required_channels_o = required_q;
  assign search_exhausted_o  = exhausted_q;

  `EBCD_ASSERT_IMP(a_mul_done_in_mul, mul_done, state_q == StMul, "multiply ended out of step")
  `EBCD_ASSERT_IMP(a_div_done_in_div, div_done, state_q == StDiv, "divide ended out of step")
  `EBCD_ASSERT_IMP(a_step_in_range, state_q != StIdle, (i_q != '0) && (i_q <= last_q),
                   "step index outside 1..last")
  `EBCD_ASSERT_IMP(a_exhausted_no_count, done_o && search_exhausted_o,
                   required_channels_o == '0, "exhausted search reports a count")

endmodule

// ----- tb/tb_erlang_b_channel_dimensioner.sv -----
`timescale 1ns / 1ps

module tb_erlang_b_channel_dimensioner;
  import ebcd_pkg::*;

  localparam int unsigned CycleLimit  = 20_000_000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned SettleCycles = 60;

  // One result word of the dimensioner
  typedef struct packed {
    logic [ProbW-1:0]  blocking;
    logic [CountW-1:0] required;
    logic              exhausted;
  } dim_result_t;

  // Tracks expected blocking and channel counts and checks returned words
  class dimension_scoreboard;
    logic [CountW-1:0] search_limit;
    dim_result_t       pending_dims[$];
    int unsigned       words_seen;
    int unsigned       results_seen;
    int unsigned       mismatches;
    int unsigned       exhausted_seen;
    int unsigned       found_seen;

    function new();
      search_limit   = SearchLimitReset;
      words_seen     = 0;
      results_seen   = 0;
      mismatches     = 0;
      exhausted_seen = 0;
      found_seen     = 0;
    endfunction

    // Run the Erlang B recursion once for both the query and the search
    function dim_result_t erlang_dimension(logic [TrafficW-1:0] traffic,
                                           logic [CountW-1:0] count,
                                           logic [ProbW-1:0] target);
      longint unsigned load, prob, ab, den, blocking, goal;
      int unsigned     n, lim, last, i, required;
      bit              searching, found;
      dim_result_t     res;
      load      = traffic;
      goal      = target;
      prob      = 64'd1 << ProbFracBits;
      blocking  = 0;
      required  = 0;
      found     = 1'b0;
      searching = (traffic != 0) && (target != 0);
      n         = count;
      lim       = search_limit;
      if (n > MaxChannels) n = MaxChannels;
      if (lim > MaxChannels) lim = MaxChannels;
      last = n;
      if (searching && lim > last) last = lim;
      for (i = 1; i <= last; i++) begin
        ab   = (load * prob) >> TrafficFracBits;
        den  = (longint'(i) << ProbFracBits) + ab;
        prob = (ab << ProbFracBits) / den;
        if (i == n) blocking = prob;
        if (searching && !found && i <= lim && prob <= goal) begin
          found    = 1'b1;
          required = i;
        end
      end
      res.blocking  = ProbW'(blocking);
      res.required  = CountW'(required);
      res.exhausted = searching && !found;
      return res;
    endfunction

    // Queue the expected answer for an accepted word
    function void note_word(logic [TrafficW-1:0] traffic, logic [CountW-1:0] count,
                            logic [ProbW-1:0] target);
      dim_result_t want;
      want = erlang_dimension(traffic, count, target);
      pending_dims.push_back(want);
      words_seen++;
      if (want.exhausted) exhausted_seen++;
      if (want.required != 0) found_seen++;
    endfunction

    // Compare a returned word with the oldest expectation
    function void check_word(dim_result_t got);
      dim_result_t want;
      results_seen++;
      if (pending_dims.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("[%0t] unexpected result: blocking=%0d required=%0d exhausted=%0b",
                   $realtime, got.blocking, got.required, got.exhausted);
        return;
      end
      want = pending_dims.pop_front();
      if (got.blocking !== want.blocking || got.required !== want.required ||
          got.exhausted !== want.exhausted) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("[%0t] mismatch: blocking %0d/%0d required %0d/%0d exhausted %0b/%0b %s",
                   $realtime, got.blocking, want.blocking, got.required, want.required,
                   got.exhausted, want.exhausted, "(actual/expected)");
      end
    endfunction

    function int unsigned pending();
      return pending_dims.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [TrafficW-1:0] offered_traffic_i;
  logic [CountW-1:0]   channel_count_i;
  logic [ProbW-1:0]    target_blocking_i;
  logic                cfg_we_i;
  logic [CountW-1:0]   cfg_wdata_i;
  logic                done_o;
  logic [ProbW-1:0]    blocking_prob_o;
  logic [CountW-1:0]   required_channels_o;
  logic                search_exhausted_o;

  dimension_scoreboard sb;
  int unsigned         cycle_cnt;
  int unsigned         burst_left;
  bit                  idle_off;
  int unsigned         settings_seen;
  int unsigned         random_words;

  erlang_b_channel_dimensioner dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .offered_traffic_i   (offered_traffic_i),
    .channel_count_i     (channel_count_i),
    .target_blocking_i   (target_blocking_i),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .done_o              (done_o),
    .blocking_prob_o     (blocking_prob_o),
    .required_channels_o (required_channels_o),
    .search_exhausted_o  (search_exhausted_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bound the run length
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Observe accepted words and returned results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        sb.check_word('{blocking: blocking_prob_o, required: required_channels_o,
                        exhausted: search_exhausted_o});
      if (start && !busy)
        sb.note_word(offered_traffic_i, channel_count_i, target_blocking_i);
    end
  end

  // Present one word and hold it until the block takes it
  task automatic send_word(input logic [TrafficW-1:0] traffic, input logic [CountW-1:0] count,
                           input logic [ProbW-1:0] target);
    start             <= 1'b1;
    offered_traffic_i <= traffic;
    channel_count_i   <= count;
    target_blocking_i <= target;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Keep words back to back within a burst, idle between bursts unless idle_off is set
  task automatic pace();
    int unsigned gap;
    if (idle_off) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 30);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(0, 7);
    end
  endtask

  // Drop start and wait for every outstanding result
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Load a new search limit while the block is idle
  task automatic write_limit(input logic [CountW-1:0] value);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.search_limit = value;
    settings_seen++;
  endtask

  task automatic send_paced(input logic [TrafficW-1:0] traffic,
                            input logic [CountW-1:0] count, input logic [ProbW-1:0] target);
    send_word(traffic, count, target);
    pace();
  endtask

  // Mostly loads sized to the limit so searches end inside it, plus noise
  task automatic run_random_phase(input int unsigned lim, input int unsigned count);
    int unsigned         k;
    int unsigned         kind;
    logic [TrafficW-1:0] traffic;
    logic [CountW-1:0]   chans;
    logic [ProbW-1:0]    target;
    write_limit(CountW'(lim));
    idle_off   = ($urandom_range(0, 3) == 0);
    burst_left = $urandom_range(0, 7);
    for (k = 0; k < count; k++) begin
      kind    = $urandom_range(0, 9);
      traffic = TrafficW'($urandom_range(0, (lim + 2) * 1024 - 1));
      chans   = CountW'($urandom_range(0, lim + 8));
      if ($urandom_range(0, 1) == 0)
        target = ProbW'($urandom_range(1, 32'h100_0000));
      else
        target = ProbW'($urandom_range(1, 32'h4_0000));
      case (kind)
        7: begin
          traffic = TrafficW'($urandom);
          target  = ProbW'($urandom_range(0, 32'h1FF_FFFF));
        end
        8: begin
          if ($urandom_range(0, 1) == 0) traffic = '0;
          else target = '0;
        end
        9: begin
          target = ProbW'($urandom_range(32'h100_0000, 32'h1FF_FFFF));
        end
        default: ;
      endcase
      // An occasional long query exercises the upper count bits
      if (random_words % 25 == 24)
        chans = CountW'($urandom_range(512, MaxChannels));
      random_words++;
      send_paced(traffic, chans, target);
    end
    drain();
  endtask

  // Main sequence
  initial begin
    sb                = new();
    settings_seen     = 1;
    random_words      = 0;
    idle_off          = 1'b0;
    burst_left        = 0;
    rst_ni            <= 1'b0;
    start             <= 1'b0;
    offered_traffic_i <= '0;
    channel_count_i   <= '0;
    target_blocking_i <= '0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset limit: empty query, idle load at full count, a real search, zero target
    send_paced('0, '0, '0);
    send_paced('0, CountW'(MaxChannels), 25'h1FF_FFFF);
    send_paced(20'd20480, 10'd30, 25'd167772);
    send_paced(20'd20480, 10'd10, '0);
    drain();

    // Top limit: hopeless search at full load, target above one
    write_limit(CountW'(MaxChannels));
    send_paced(20'hF_FFFF, 10'd512, 25'd1);
    send_paced(20'h5_5555, 10'd7, 25'h100_0001);
    drain();

    // Single-channel limit: met, missed, exactly one, tiny load
    write_limit(10'd1);
    send_paced(20'd512, 10'd1, 25'd8388608);
    send_paced(20'd512, 10'd1, 25'd1677722);
    send_paced(20'hF_FFFF, 10'd3, 25'h100_0000);
    send_paced(20'd1, 10'd2, 25'd1);
    drain();

    // Zero limit: no channel count is tried against the target, so a search is exhausted
    write_limit(10'd0);
    send_paced(20'd102400, 10'd4, 25'd1000);
    send_paced('0, 10'd4, 25'd1000);
    send_paced(20'd102400, '0, '0);
    drain();

    // Moderate limit: alternating bit patterns and a zero-count query
    write_limit(10'd16);
    send_paced(20'd5120, 10'd16, 25'd335544);
    send_paced(20'hA_AAAA, 10'd5, 25'hAA_AAAA);
    send_paced(20'h5_5555, 10'd10, 25'h155_5555);
    send_paced(20'd1024, '0, 25'h1FF_FFFF);
    send_paced(20'd2048, 10'd9, 25'd1);
    drain();

    // Random loads over several small search limits
    run_random_phase($urandom_range(1, 12), 20);
    run_random_phase($urandom_range(13, 48), 20);
    run_random_phase($urandom_range(2, 48), 20);
    run_random_phase($urandom_range(1, 48), 20);

    repeat (SettleCycles) @(posedge clk_i);
    $display("Checked %0d results for %0d words (%0d random) over %0d search limits.",
             sb.results_seen, sb.words_seen, random_words, settings_seen);
    $display("Searches: %0d found a channel count, %0d exhausted; %0d mismatches.",
             sb.found_seen, sb.exhausted_seen, sb.mismatches);
    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
